/* sv/brc_pkg.sv */
`default_nettype none

package brc_pkg;

  // Field widths of the item and result formats.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned HELD_W   = 9;
  localparam int unsigned STAT_W   = 2;

  // Packed stream payloads, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 80;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLOSE = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_WRITE,
    S_READ,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

/* sv/byte_ring_channel.sv */
`default_nettype none

// Circular byte channel over a ring of size_in_use byte slots held in a
// single-port byte memory. A write item offers up to eight bytes and a read
// item asks for up to eight; each grant is clamped to the free space or the
// bytes held and to the run left before the end of the ring, and the granted
// count comes back in the result. A full ring on write or an empty ring on
// read gives a blocked status with a count of zero, and software retries. A
// close item sets a closed mark, and every result reports whether the ring is
// empty and closed. The sequencer moves one byte per cycle through the
// memory port. After the input transfer an item passes the grant state,
// the byte loop for any granted bytes and the done state, which loads the
// result into the output register once it is free. The input side is
// ready only while no item is at work; a finished result waits in the
// output register, so the next item may be taken before it is collected.
// Writing size_in_use empties the ring and keeps the closed mark. The byte
// memory has no reset and needs no clearing pass, as only written slots are
// ever read.
module byte_ring_channel #(
  parameter int unsigned DEPTH     = 256,
  parameter int unsigned MAX_CHUNK = 8
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Configuration write channel: size_in_use.
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [brc_pkg::CFG_W-1:0]       cfg_data_i,
  // Item stream.
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  // From bit 0: request_length[3:0], write_data[67:4], zeros[71:68].
  input  wire  [brc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // From bit 0: operation[1:0].
  input  wire  [brc_pkg::OP_W-1:0]        s_axis_tuser,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  // From bit 0: granted_count[3:0], read_data[67:4], bytes_held[76:68],
  // drained_and_closed[77], zeros[79:78].
  output logic [brc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // From bit 0: status[1:0].
  output logic [brc_pkg::STAT_W-1:0]      m_axis_tuser
);

  import brc_pkg::*;

  // Index width of the byte memory, and a count width that holds DEPTH and
  // any configured size alike.
  localparam int unsigned IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW  = $clog2(DEPTH + 1);
  localparam int unsigned CW  = (DW > CFG_W) ? DW : CFG_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [LEN_W-1:0] CHUNK_C = LEN_W'(MAX_CHUNK);

  // Control state.
  state_e            state_q, state_d;
  logic [CW-1:0]     size_q, size_d;
  logic [CW-1:0]     free_q, free_d;
  logic [IW-1:0]     ridx_q, ridx_d;
  logic [IW-1:0]     widx_q, widx_d;
  logic              closed_q, closed_d;
  logic              m_valid_q, m_valid_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic              pend_q, pend_d;

  // Item and working payload.
  logic [OP_W-1:0]   op_q, op_d;
  logic [LEN_W-1:0]  req_q, req_d;
  logic [DATA_W-1:0] wdata_q, wdata_d;
  logic [DATA_W-1:0] rdata_q, rdata_d;
  logic [LEN_W-1:0]  gnt_q, gnt_d;
  logic [IW-1:0]     base_q, base_d;
  status_e           stat_q, stat_d;
  logic [2:0]        pos_q, pos_d;

  // Result register.
  logic [M_TDATA_W-1:0] m_data_q, m_data_d;
  logic [STAT_W-1:0]    m_user_q, m_user_d;

  // Byte memory port.
  logic [7:0]        mem [DEPTH];
  logic [IW-1:0]     mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [7:0]        mem_rdata_q;

  // Sequencer working values.
  logic              cfg_fire;
  logic              in_fire;
  logic [CW-1:0]     cfg_ext;
  logic [CW-1:0]     cfg_size;
  logic [LEN_W-1:0]  req_clamped;
  logic [IW-1:0]     widx_eff;
  logic [IW-1:0]     ridx_eff;
  logic [CW-1:0]     lim_a;
  logic [CW-1:0]     lim_b;
  logic [CW-1:0]     gnt_wide;
  logic [CW-1:0]     idx_next;
  logic [CW-1:0]     held;
  logic              issue;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // A size of zero is taken as one, and any size beyond the memory as DEPTH.
  assign cfg_ext  = CW'(cfg_data_i);
  assign cfg_size = (cfg_ext == '0) ? CW'(1) :
                    ((cfg_ext > DEPTH_C) ? DEPTH_C : cfg_ext);

  assign req_clamped = (req_q > CHUNK_C) ? CHUNK_C : req_q;
  assign widx_eff    = (CW'(widx_q) >= size_q) ? '0 : widx_q;
  assign ridx_eff    = (CW'(ridx_q) >= size_q) ? '0 : ridx_q;

  // Bytes held after the item, for the result.
  assign held = (free_q <= size_q) ? (size_q - free_q) : '0;

  always_comb begin
    state_d   = state_q;
    size_d    = size_q;
    free_d    = free_q;
    ridx_d    = ridx_q;
    widx_d    = widx_q;
    closed_d  = closed_q;
    m_valid_d = m_valid_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    op_d      = op_q;
    req_d     = req_q;
    wdata_d   = wdata_q;
    rdata_d   = rdata_q;
    gnt_d     = gnt_q;
    base_d    = base_q;
    stat_d    = stat_q;
    pos_d     = pos_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mem_addr  = base_q + IW'(cnt_q);
    mem_we    = 1'b0;
    mem_wdata = wdata_q[{cnt_q[2:0], 3'b000} +: 8];
    lim_a     = '0;
    lim_b     = '0;
    gnt_wide  = '0;
    idx_next  = '0;
    issue     = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d    = s_axis_tuser;
          req_d   = s_axis_tdata[LEN_W-1:0];
          wdata_d = s_axis_tdata[LEN_W +: DATA_W];
          rdata_d = '0;
          gnt_d   = '0;
          cnt_d   = '0;
          pend_d  = 1'b0;
          stat_d  = ST_DONE;
          state_d = S_CALC;
        end
      end

      S_CALC: begin
        // Grant the request and commit the new indices at once; the byte
        // loop that follows only moves data through the memory port.
        state_d = S_DONE;
        unique case (op_q)
          OP_WRITE: begin
            if (free_q == '0) begin
              stat_d = ST_FULL;
            end else begin
              lim_a    = (CW'(req_clamped) < free_q) ? CW'(req_clamped) : free_q;
              lim_b    = size_q - CW'(widx_eff);
              gnt_wide = (lim_a < lim_b) ? lim_a : lim_b;
              idx_next = CW'(widx_eff) + gnt_wide;
              gnt_d    = gnt_wide[LEN_W-1:0];
              base_d   = widx_eff;
              free_d   = free_q - gnt_wide;
              widx_d   = (idx_next >= size_q) ? '0 : idx_next[IW-1:0];
              if (gnt_wide != '0) begin
                state_d = S_WRITE;
              end
            end
          end
          OP_READ: begin
            if (free_q >= size_q) begin
              stat_d = ST_EMPTY;
            end else begin
              lim_a    = size_q - free_q;
              lim_a    = (CW'(req_clamped) < lim_a) ? CW'(req_clamped) : lim_a;
              lim_b    = size_q - CW'(ridx_eff);
              gnt_wide = (lim_a < lim_b) ? lim_a : lim_b;
              idx_next = CW'(ridx_eff) + gnt_wide;
              gnt_d    = gnt_wide[LEN_W-1:0];
              base_d   = ridx_eff;
              free_d   = free_q + gnt_wide;
              ridx_d   = (idx_next >= size_q) ? '0 : idx_next[IW-1:0];
              if (gnt_wide != '0) begin
                state_d = S_READ;
              end
            end
          end
          OP_CLOSE: begin
            closed_d = 1'b1;
          end
          default: begin
          end
        endcase
      end

      S_WRITE: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + LEN_W'(1);
        if (cnt_q + LEN_W'(1) == gnt_q) begin
          state_d = S_DONE;
        end
      end

      S_READ: begin
        // Reads are issued one byte a cycle; each byte lands in the next cycle.
        issue = (cnt_q < gnt_q);
        if (issue) begin
          cnt_d = cnt_q + LEN_W'(1);
          pos_d = cnt_q[2:0];
        end
        pend_d = issue;
        if (pend_q) begin
          rdata_d[{pos_q, 3'b000} +: 8] = mem_rdata_q;
        end
        if (!issue && !pend_q) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {2'b00,
                       (closed_q && (held == '0)),
                       held[HELD_W-1:0],
                       rdata_q,
                       gnt_q};
          m_user_d  = stat_q;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Size write empties ring; user must send it only while idle (unchecked).
    if (cfg_fire) begin
      size_d = cfg_size;
      free_d = cfg_size;
      ridx_d = '0;
      widx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      size_q    <= DEPTH_C;
      free_q    <= DEPTH_C;
      ridx_q    <= '0;
      widx_q    <= '0;
      closed_q  <= 1'b0;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      size_q    <= size_d;
      free_q    <= free_d;
      ridx_q    <= ridx_d;
      widx_q    <= widx_d;
      closed_q  <= closed_d;
      m_valid_q <= m_valid_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    req_q    <= req_d;
    wdata_q  <= wdata_d;
    rdata_q  <= rdata_d;
    gnt_q    <= gnt_d;
    base_q   <= base_d;
    stat_q   <= stat_d;
    pos_q    <= pos_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  // Single-port byte memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_addr];
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

// Checks byte_ring_channel against a behavioural ring model kept inside this
// module. A short directed list walks the extremes (empty and full rings,
// long and zero-length requests, close, the unused operation code and size
// rewrites of 0, 1, 5 and 511). Random phases then follow, each at a new ring
// size, with bursty input and a patterned stall on the result side.
module testbench;
  import brc_pkg::*;

  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned CHUNK_MAX  = 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 85;

  typedef struct packed {
    logic [LEN_W-1:0]  count;
    logic [DATA_W-1:0] rdata;
    logic [STAT_W-1:0] status;
    logic [HELD_W-1:0] held;
    logic              drained;
  } ring_result_t;

  typedef enum bit {ROW_ITEM, ROW_SIZE} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [CFG_W-1:0]  size;
    logic [OP_W-1:0]   op;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    bit                typed;
    ring_result_t      want;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  wire                  cfg_ready_o;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]      s_axis_tuser = '0;
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  wire  [M_TDATA_W-1:0] m_axis_tdata;
  wire  [STAT_W-1:0]    m_axis_tuser;

  byte_ring_channel dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Ring model state.
  logic [7:0]  ring_bytes [RING_DEPTH];
  int unsigned ring_size  = RING_DEPTH;
  int unsigned rd_pos     = 0;
  int unsigned wr_pos     = 0;
  int unsigned ring_free  = RING_DEPTH;
  bit          closed_flag = 1'b0;

  ring_result_t pending_results[$];
  row_t         stim_rows[$];
  int unsigned  error_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  results_checked = 0;
  int unsigned  full_refusals = 0;
  int unsigned  empty_refusals = 0;
  int unsigned  sizes_used = 0;

  function automatic int unsigned min_u(int unsigned a, int unsigned b);
    return (a < b) ? a : b;
  endfunction

  // A size write empties the ring but leaves the closed mark alone.
  function automatic void ring_resize(logic [CFG_W-1:0] v);
    if (v == 0) ring_size = 1;
    else if (v > RING_DEPTH) ring_size = RING_DEPTH;
    else ring_size = v;
    rd_pos = 0;
    wr_pos = 0;
    ring_free = ring_size;
  endfunction

  function automatic ring_result_t ring_step(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                             logic [DATA_W-1:0] data);
    ring_result_t r;
    int unsigned n;
    int unsigned held;
    r = '0;
    n = (len > CHUNK_MAX) ? CHUNK_MAX : len;
    case (op)
      OP_WRITE: begin
        if (ring_free == 0) begin
          r.status = ST_FULL;
        end else begin
          if (wr_pos >= ring_size) wr_pos = 0;
          n = min_u(min_u(n, ring_free), ring_size - wr_pos);
          for (int unsigned i = 0; i < n; i++) ring_bytes[wr_pos + i] = data[8*i +: 8];
          ring_free -= n;
          wr_pos += n;
          if (wr_pos >= ring_size) wr_pos = 0;
          r.count = LEN_W'(n);
        end
      end
      OP_READ: begin
        if (ring_free >= ring_size) begin
          r.status = ST_EMPTY;
        end else begin
          if (rd_pos >= ring_size) rd_pos = 0;
          n = min_u(min_u(n, ring_size - ring_free), ring_size - rd_pos);
          for (int unsigned i = 0; i < n; i++) r.rdata[8*i +: 8] = ring_bytes[rd_pos + i];
          ring_free += n;
          rd_pos += n;
          if (rd_pos >= ring_size) rd_pos = 0;
          r.count = LEN_W'(n);
        end
      end
      OP_CLOSE: closed_flag = 1'b1;
      default: ;
    endcase
    held = ring_size - ring_free;
    r.held = HELD_W'(held);
    r.drained = closed_flag && (held == 0);
    return r;
  endfunction

  function automatic row_t item_row(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                    logic [DATA_W-1:0] data);
    row_t r;
    r = '{kind: ROW_ITEM, size: '0, op: op, len: len, data: data, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t typed_row(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                     logic [DATA_W-1:0] data, logic [LEN_W-1:0] count,
                                     logic [DATA_W-1:0] rdata, logic [STAT_W-1:0] status,
                                     logic [HELD_W-1:0] held, logic drained);
    row_t r;
    r = item_row(op, len, data);
    r.typed = 1'b1;
    r.want = '{count: count, rdata: rdata, status: status, held: held, drained: drained};
    return r;
  endfunction

  function automatic row_t size_row(logic [CFG_W-1:0] v);
    row_t r;
    r = item_row(OP_WRITE, '0, '0);
    r.kind = ROW_SIZE;
    r.size = v;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $time, results_checked, what, got, want);
    error_count++;
  endtask

  // Raises tvalid and holds it until the transfer; the caller lowers it
  // when a gap follows, so tvalid is never dropped and raised in one step.
  task automatic send_item(row_t row);
    ring_result_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, row.data, row.len};
    s_axis_tuser  <= row.op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = ring_step(row.op, row.len, row.data);
    pending_results.push_back(row.typed ? row.want : predicted);
    items_sent++;
  endtask

  // Size writes are only made once every outstanding result has come back.
  task automatic write_size(logic [CFG_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    ring_resize(v);
    sizes_used++;
  endtask

  // Result side: a ready pattern from a 16-bit mask that is redrawn each time the
  // phase counter wraps, sometimes fully open.
  logic [5:0]  stall_phase = '0;
  logic [15:0] stall_mask = 16'hffff;

  always @(posedge clk_i) begin
    if (stall_phase == 6'd63) begin
      if ($urandom_range(0, 3) == 0) stall_mask <= 16'hffff;
      else stall_mask <= 16'($urandom_range(0, 65535)) | 16'h0001;
    end
    stall_phase <= stall_phase + 6'd1;
    m_axis_tready <= stall_mask[stall_phase[3:0]];
  end

  always @(posedge clk_i) begin : result_check
    ring_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, read_data", m_axis_tdata[67:4], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[3:0] !== want.count)
          report_mismatch("granted_count", 64'(m_axis_tdata[3:0]), 64'(want.count));
        if (m_axis_tdata[67:4] !== want.rdata)
          report_mismatch("read_data", m_axis_tdata[67:4], want.rdata);
        if (m_axis_tdata[76:68] !== want.held)
          report_mismatch("bytes_held", 64'(m_axis_tdata[76:68]), 64'(want.held));
        if (m_axis_tdata[77] !== want.drained)
          report_mismatch("drained_and_closed", 64'(m_axis_tdata[77]), 64'(want.drained));
        if (m_axis_tuser !== want.status)
          report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
        if (want.status == ST_FULL) full_refusals++;
        if (want.status == ST_EMPTY) empty_refusals++;
      end
      results_checked++;
    end
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] phase_size;
    logic [OP_W-1:0]  op;
    logic [LEN_W-1:0] len;
    int unsigned      write_weight;
    int unsigned      pick;
    int unsigned      burst_left;
    int unsigned      gap;
    bit               no_gaps;
    int unsigned      fixed_sizes [8];

    fixed_sizes = '{1, 2, 256, 3, 8, 9, 17, 255};

    // Directed list; the ring starts at 256 slots.
    stim_rows.push_back(typed_row(OP_READ, 4, '0, 0, '0, ST_EMPTY, 0, 0));
    stim_rows.push_back(typed_row(OP_WRITE, 0, '1, 0, '0, ST_DONE, 0, 0));
    stim_rows.push_back(typed_row(OP_READ, 0, '0, 0, '0, ST_EMPTY, 0, 0));
    stim_rows.push_back(typed_row(OP_WRITE, 8, '1, 8, '0, ST_DONE, 8, 0));
    stim_rows.push_back(typed_row(OP_WRITE, 15, 64'h0123_4567_89ab_cdef,
                                  8, '0, ST_DONE, 16, 0));
    stim_rows.push_back(typed_row(OP_READ, 15, '0, 8, '1, ST_DONE, 8, 0));
    stim_rows.push_back(typed_row(OP_READ, 0, '0, 0, '0, ST_DONE, 8, 0));
    stim_rows.push_back(item_row(OP_READ, 3, '0));
    stim_rows.push_back(item_row(OP_UNUSED, 5, 64'hdead_beef_0000_ffff));
    stim_rows.push_back(item_row(OP_CLOSE, 0, '0));
    stim_rows.push_back(item_row(OP_READ, 8, '0));
    // Closed and drained: reads still refuse as empty.
    stim_rows.push_back(typed_row(OP_READ, 2, '0, 0, '0, ST_EMPTY, 0, 1));
    stim_rows.push_back(item_row(OP_CLOSE, 9, '1));
    // Single-slot ring.
    stim_rows.push_back(size_row(1));
    stim_rows.push_back(typed_row(OP_WRITE, 8, 64'h5a5a_5a5a_5a5a_5aa5,
                                  1, '0, ST_DONE, 1, 0));
    stim_rows.push_back(typed_row(OP_WRITE, 1, '0, 0, '0, ST_FULL, 1, 0));
    stim_rows.push_back(typed_row(OP_READ, 8, '0, 1, 64'ha5, ST_DONE, 0, 1));
    // Out-of-range sizes are clamped.
    stim_rows.push_back(size_row(0));
    stim_rows.push_back(item_row(OP_WRITE, 2, 64'h3c));
    stim_rows.push_back(size_row(511));
    stim_rows.push_back(item_row(OP_WRITE, 8, '0));
    // Five slots: the write stops at the end of the ring, then wraps.
    stim_rows.push_back(size_row(5));
    stim_rows.push_back(item_row(OP_WRITE, 3, 64'h11_2233));
    stim_rows.push_back(item_row(OP_WRITE, 8, 64'hffee_ddcc_bbaa_9988));
    stim_rows.push_back(typed_row(OP_WRITE, 1, '0, 0, '0, ST_FULL, 5, 0));
    stim_rows.push_back(item_row(OP_READ, 8, '0));
    stim_rows.push_back(item_row(OP_WRITE, 8, 64'h7766_5544_3322_1100));
    stim_rows.push_back(item_row(OP_READ, 4, '0));
    stim_rows.push_back(item_row(OP_READ, 8, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_SIZE) write_size(stim_rows[i].size);
      else send_item(stim_rows[i]);
    end

    // Random phases: write-heavy and read-heavy in turn so that both the
    // full and the empty ring are reached at small sizes.
    for (int unsigned p = 0; p < PHASES; p++) begin
      phase_size = (p < 8) ? CFG_W'(fixed_sizes[p]) : CFG_W'($urandom_range(1, RING_DEPTH));
      write_size(phase_size);
      write_weight = (p % 2 == 0) ? $urandom_range(55, 85) : $urandom_range(20, 45);
      no_gaps = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) op = OP_CLOSE;
        else if (pick < 8) op = OP_UNUSED;
        else if (pick < 8 + write_weight) op = OP_WRITE;
        else op = OP_READ;
        case ($urandom_range(0, 9))
          0: len = 0;
          1: len = LEN_W'($urandom_range(9, 15));
          default: len = LEN_W'($urandom_range(1, CHUNK_MAX));
        endcase
        if (burst_left == 0) begin
          gap = no_gaps ? 0 : $urandom_range(0, 6);
          burst_left = $urandom_range(1, 24);
          if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
        end
        send_item(item_row(op, len, {$urandom, $urandom}));
        burst_left--;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("Ran %0d items over %0d ring size settings; %0d results checked.",
             items_sent, sizes_used, results_checked);
    $display("Refusals seen: %0d on a full ring, %0d on an empty ring.",
             full_refusals, empty_refusals);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
